### sv/rwc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, register indexes and reset values for the raycaster
// wall column setup block. No dependencies.
package rwc_pkg;

  // Fixed point and size limits
  localparam int FRAC_BITS   = 16;
  localparam int DIR_FRAC    = 14;
  localparam int MAX_ROWS    = 2048;
  localparam int MAX_TEX_DIM = 1024;

  // Field widths
  localparam int SCREEN_W = 12;
  localparam int TEX_W    = 11;
  localparam int POS_W    = 24;
  localparam int DIR_W    = 16;
  localparam int DIST_W   = 24;
  localparam int LH_W     = 16;
  localparam int ID_W     = 2;
  localparam int ROW_W    = 11;
  localparam int COL_W    = 10;
  localparam int FIX_W    = 26;

  // Derived widths
  localparam int FRAC_TOT = FRAC_BITS + DIR_FRAC;         // wall coordinate fraction
  localparam int H_W      = $clog2(MAX_ROWS + 1);         // clamped screen height
  localparam int TW_W     = $clog2(MAX_TEX_DIM + 1);      // clamped texture width
  localparam int RW       = LH_W + 1;                     // row arithmetic
  localparam int OFF_W    = LH_W - 1;                     // start offset, at most lh/2
  localparam int CP_W     = FRAC_TOT + TW_W;              // column product
  localparam int NUM_W    = TEX_W + OFF_W + FRAC_BITS;    // widest dividend
  localparam int NUMX_W   = (NUM_W > FIX_W + LH_W) ? NUM_W : FIX_W + LH_W;
  localparam int TOP_W    = NUMX_W - FIX_W;               // dividend bits above quotient
  localparam int CNT_W    = $clog2(FIX_W);

  // Divider lanes: texel step and texel start
  localparam int DIV_LANES = 2;
  localparam int LANE_STEP  = 0;
  localparam int LANE_START = 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_REGS   = 5;
  localparam int CFG_IDX_W  = $clog2(CFG_REGS);
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y       = CFG_IDX_W'(4);

  // Texture codes
  localparam logic [ID_W-1:0] TEX_EAST  = ID_W'(0);
  localparam logic [ID_W-1:0] TEX_WEST  = ID_W'(1);
  localparam logic [ID_W-1:0] TEX_SOUTH = ID_W'(2);
  localparam logic [ID_W-1:0] TEX_NORTH = ID_W'(3);

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_height;
    logic [TEX_W-1:0]    texture_width;
    logic [TEX_W-1:0]    texture_height;
    logic [POS_W-1:0]    viewer_x;
    logic [POS_W-1:0]    viewer_y;
  } rwc_cfg_t;

  localparam rwc_cfg_t CFG_RESET = '{
    screen_height:  SCREEN_W'(480),
    texture_width:  TEX_W'(64),
    texture_height: TEX_W'(64),
    viewer_x:       POS_W'(0),
    viewer_y:       POS_W'(0)
  };

  // One classified ray waiting for the back end
  typedef struct packed {
    logic [ID_W-1:0]     tex_id;
    logic [ROW_W-1:0]    first_row;
    logic [ROW_W-1:0]    final_row;
    logic [FRAC_TOT-1:0] frac;
    logic                mirror;
    logic [OFF_W-1:0]    off;
    logic [LH_W-1:0]     wall_height;
  } rwc_job_t;

endpackage

### sv/rwc_fifo.sv
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
// Depends on rwc_pkg.
module rwc_fifo import rwc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rwc_job_t job_in,
  output logic     full,
  input  logic     pop,
  output rwc_job_t job_out,
  output logic     empty
);

  rwc_job_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign job_out = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

### sv/rwc_front.sv
`timescale 1ns / 1ps
// Front end: accepts a ray, picks the texture, clamps the rows and forms the
// wall coordinate fraction, then queues the job. Depends on rwc_pkg.
module rwc_front import rwc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rwc_cfg_t                cfg,
  input  logic                    in_push,
  input  logic                    in_hit_side,
  input  logic signed [DIR_W-1:0] in_direction_x,
  input  logic signed [DIR_W-1:0] in_direction_y,
  input  logic [DIST_W-1:0]       in_hit_distance,
  input  logic [LH_W-1:0]         in_wall_height,
  input  logic                    q_full,
  output logic                    q_push,
  output rwc_job_t                q_job
);

  logic [ID_W-1:0]          last_tex_r, last_tex_nxt;
  logic [H_W-1:0]           h;
  logic [RW-1:0]            h_x, half_x, lh2_x, sum_x;
  logic                     lh2_ge;
  logic [RW-1:0]            first_x, final_x, off_x;
  logic [POS_W-1:0]         pos;
  logic signed [DIR_W-1:0]  dir;
  logic [POS_W+DIR_FRAC-1:0] pos_sh;
  logic signed [DIST_W+DIR_W:0] prod;

  assign q_push = in_push && !q_full;

  // Texture choice; a zero component on the crossed axis keeps the last one
  always_comb begin
    last_tex_nxt = last_tex_r;
    if (!in_hit_side) begin
      if (in_direction_x < 0) begin
        last_tex_nxt = TEX_EAST;
      end else if (in_direction_x > 0) begin
        last_tex_nxt = TEX_WEST;
      end
    end else begin
      if (in_direction_y < 0) begin
        last_tex_nxt = TEX_SOUTH;
      end else if (in_direction_y > 0) begin
        last_tex_nxt = TEX_NORTH;
      end
    end
  end

  // Row window around the screen center
  always_comb begin
    h       = (32'(cfg.screen_height) > MAX_ROWS) ? H_W'(MAX_ROWS) : H_W'(cfg.screen_height);
    h_x     = RW'(h);
    half_x  = RW'(h >> 1);
    lh2_x   = RW'(in_wall_height >> 1);
    sum_x   = half_x + lh2_x;
    lh2_ge  = (lh2_x >= half_x);
    first_x = lh2_ge ? '0 : half_x - lh2_x;
    off_x   = lh2_ge ? lh2_x - half_x : '0;
    if (sum_x >= h_x) begin
      final_x = (h == '0) ? '0 : h_x - 1'b1;
    end else begin
      final_x = sum_x;
    end
  end

  // Fraction of the hit position along the wall
  always_comb begin
    pos    = in_hit_side ? cfg.viewer_x : cfg.viewer_y;
    dir    = in_hit_side ? in_direction_x : in_direction_y;
    pos_sh = {pos, {DIR_FRAC{1'b0}}};
    prod   = (DIST_W+DIR_W+1)'($signed({1'b0, in_hit_distance})) *
             (DIST_W+DIR_W+1)'(dir);
  end

  always_comb begin
    q_job.tex_id      = last_tex_nxt;
    q_job.first_row   = ROW_W'(first_x);
    q_job.final_row   = ROW_W'(final_x);
    q_job.frac        = pos_sh[FRAC_TOT-1:0] + prod[FRAC_TOT-1:0];
    q_job.mirror      = (!in_hit_side && (in_direction_x > 0)) ||
                        (in_hit_side && (in_direction_y < 0));
    q_job.off         = OFF_W'(off_x);
    q_job.wall_height = in_wall_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tex_r <= TEX_EAST;
    end else if (q_push) begin
      last_tex_r <= last_tex_nxt;
    end
  end

endmodule

### sv/rwc_div.sv
`timescale 1ns / 1ps
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle,
// with overflow saturation to all ones. Depends on rwc_pkg.
module rwc_div import rwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LH_W-1:0]   divisor,
  input  logic [NUMX_W-1:0] num [DIV_LANES],
  output logic              busy,
  output logic [FIX_W-1:0]  quot [DIV_LANES]
);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LH_W-1:0]    dvs_r, dvs_nxt;
  logic [TOP_W-1:0]   top_r [DIV_LANES];
  logic [TOP_W-1:0]   top_nxt [DIV_LANES];
  logic [FIX_W-1:0]   nq_r [DIV_LANES];
  logic [FIX_W-1:0]   nq_nxt [DIV_LANES];
  logic [LH_W-1:0]    rem_r [DIV_LANES];
  logic [LH_W-1:0]    rem_nxt [DIV_LANES];
  logic               ovf_r [DIV_LANES];
  logic               ovf_nxt [DIV_LANES];
  logic [LH_W:0]      r_ext [DIV_LANES];
  logic [LH_W:0]      diff [DIV_LANES];
  logic               ge [DIV_LANES];

  assign busy = (state_r != D_IDLE);

  // Per-lane trial subtract
  always_comb begin
    for (int i = 0; i < DIV_LANES; i++) begin
      r_ext[i] = {rem_r[i], nq_r[i][FIX_W-1]};
      diff[i]  = r_ext[i] - {1'b0, dvs_r};
      ge[i]    = (r_ext[i] >= {1'b0, dvs_r});
      quot[i]  = ovf_r[i] ? '1 : nq_r[i];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvs_nxt   = dvs_r;
    for (int i = 0; i < DIV_LANES; i++) begin
      top_nxt[i] = top_r[i];
      nq_nxt[i]  = nq_r[i];
      rem_nxt[i] = rem_r[i];
      ovf_nxt[i] = ovf_r[i];
    end
    case (state_r)
      D_IDLE: begin
        if (start) begin
          dvs_nxt = divisor;
          cnt_nxt = CNT_W'(FIX_W - 1);
          for (int i = 0; i < DIV_LANES; i++) begin
            top_nxt[i] = num[i][NUMX_W-1:FIX_W];
            nq_nxt[i]  = num[i][FIX_W-1:0];
          end
          state_nxt = D_CHECK;
        end
      end
      D_CHECK: begin
        // quotient too wide for the result when the high part reaches the divisor
        for (int i = 0; i < DIV_LANES; i++) begin
          ovf_nxt[i] = (top_r[i] >= TOP_W'(dvs_r));
          rem_nxt[i] = top_r[i][LH_W-1:0];
        end
        state_nxt = D_RUN;
      end
      D_RUN: begin
        for (int i = 0; i < DIV_LANES; i++) begin
          rem_nxt[i] = ge[i] ? diff[i][LH_W-1:0] : r_ext[i][LH_W-1:0];
          nq_nxt[i]  = {nq_r[i][FIX_W-2:0], ge[i]};
        end
        if (cnt_r == '0) begin
          state_nxt = D_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      for (int i = 0; i < DIV_LANES; i++) begin
        ovf_r[i] <= 1'b0;
        nq_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      for (int i = 0; i < DIV_LANES; i++) begin
        ovf_r[i] <= ovf_nxt[i];
        nq_r[i]  <= nq_nxt[i];
      end
    end
    cnt_r <= cnt_nxt;
    dvs_r <= dvs_nxt;
    for (int i = 0; i < DIV_LANES; i++) begin
      top_r[i] <= top_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
  end

endmodule

### sv/rwc_back.sv
`timescale 1ns / 1ps
// Back end: takes queued jobs, computes the texel column and runs the step and
// start divisions, then holds the result in the output register.
// Depends on rwc_pkg and rwc_div.
module rwc_back import rwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rwc_cfg_t          cfg,
  input  logic              q_empty,
  input  rwc_job_t          q_job,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [ID_W-1:0]   out_texture_id,
  output logic [ROW_W-1:0]  out_first_row,
  output logic [ROW_W-1:0]  out_final_row,
  output logic [COL_W-1:0]  out_texel_column,
  output logic [FIX_W-1:0]  out_texel_step,
  output logic [FIX_W-1:0]  out_texel_start
);

  typedef enum logic [1:0] {B_IDLE, B_PREP, B_WAIT, B_DONE} state_t;

  state_t                  state_r, state_nxt;
  rwc_job_t                job_r, job_nxt;
  logic [CP_W-1:0]         col_prod_r, col_prod_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]         tex_r, tex_nxt;
  logic [ROW_W-1:0]        first_r, first_nxt;
  logic [ROW_W-1:0]        final_r, final_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [FIX_W-1:0]        step_r, step_nxt;
  logic [FIX_W-1:0]        start_r, start_nxt;

  logic                    load_out;
  logic                    div_start;
  logic                    div_busy;
  logic [NUMX_W-1:0]       div_num [DIV_LANES];
  logic [FIX_W-1:0]        div_quot [DIV_LANES];
  logic [TW_W-1:0]         w;
  logic [OFF_W+TEX_W-1:0]  start_prod;
  logic [TW_W-1:0]         col_raw, col_fin;

  assign w = (32'(cfg.texture_width) > MAX_TEX_DIM) ? TW_W'(MAX_TEX_DIM)
                                                   : TW_W'(cfg.texture_width);

  // Dividends: texture height, and offset times texture height, both scaled
  assign start_prod                = (OFF_W+TEX_W)'(job_r.off) *
                                     (OFF_W+TEX_W)'(cfg.texture_height);
  assign div_num[LANE_STEP]  = NUMX_W'(cfg.texture_height) << FRAC_BITS;
  assign div_num[LANE_START] = NUMX_W'(start_prod) << FRAC_BITS;

  rwc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (job_r.wall_height),
    .num     (div_num),
    .busy    (div_busy),
    .quot    (div_quot)
  );

  // Texel column, mirrored for walls seen from the far side
  always_comb begin
    col_raw = col_prod_r[CP_W-1:FRAC_TOT];
    if (job_r.mirror) begin
      col_fin = (w == '0) ? '0 : w - 1'b1 - col_raw;
    end else begin
      col_fin = col_raw;
    end
  end

  // Job sequencer
  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    col_prod_nxt = col_prod_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          state_nxt = B_PREP;
        end
      end
      B_PREP: begin
        div_start    = 1'b1;
        col_prod_nxt = CP_W'(job_r.frac) * CP_W'(w);
        state_nxt    = B_WAIT;
      end
      B_WAIT: begin
        if (!div_busy) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_pop) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = load_out || (out_valid_r && !out_pop);
    tex_nxt       = tex_r;
    first_nxt     = first_r;
    final_nxt     = final_r;
    col_nxt       = col_r;
    step_nxt      = step_r;
    start_nxt     = start_r;
    if (load_out) begin
      tex_nxt   = job_r.tex_id;
      first_nxt = job_r.first_row;
      final_nxt = job_r.final_row;
      col_nxt   = COL_W'(col_fin);
      step_nxt  = div_quot[LANE_STEP];
      // zero line height: start row of the texture is zero
      start_nxt = (job_r.wall_height == '0) ? '0 : div_quot[LANE_START];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    col_prod_r <= col_prod_nxt;
    tex_r      <= tex_nxt;
    first_r    <= first_nxt;
    final_r    <= final_nxt;
    col_r      <= col_nxt;
    step_r     <= step_nxt;
    start_r    <= start_nxt;
  end

  assign out_empty        = !out_valid_r;
  assign out_texture_id   = tex_r;
  assign out_first_row    = first_r;
  assign out_final_row    = final_r;
  assign out_texel_column = col_r;
  assign out_texel_step   = step_r;
  assign out_texel_start  = start_r;

endmodule

### sv/raycast_wall_column_setup_unit.sv
`timescale 1ns / 1ps
// Raycaster wall column setup: one hit ray in, one wall slice description out.
// Input channel: present a ray with in_push; it is taken on a clock edge where
//   in_full is low. A two-entry job queue sits behind the front end, so up to
//   two rays can be taken while the back end is busy.
// Result channel: while out_empty is low the oldest result is on the out_
//   ports; it is taken on an edge where out_pop is high.
// Configuration: cfg_write_en writes cfg_data into register cfg_index on the
//   next edge; write only while no ray is in flight.
// The back end handles one ray at a time: the shared two-lane divider, which
//   produces one quotient bit per cycle for the 26-bit step and start values,
//   must finish before the back end takes the next ray from the queue.
// A stalled receiver holds the result in the output register; the back end
//   then waits with the next finished ray, and the queue keeps taking rays
//   until it is full.
// Reset (rst_n low, synchronous) empties the queue and output, loads the
//   configuration defaults and selects the east texture as last texture.
// Depends on rwc_pkg, rwc_fifo, rwc_front, rwc_back.
module raycast_wall_column_setup_unit import rwc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_write_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_hit_side,
  input  logic signed [DIR_W-1:0] in_direction_x,
  input  logic signed [DIR_W-1:0] in_direction_y,
  input  logic [DIST_W-1:0]       in_hit_distance,
  input  logic [LH_W-1:0]         in_wall_height,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [ID_W-1:0]         out_texture_id,
  output logic [ROW_W-1:0]        out_first_row,
  output logic [ROW_W-1:0]        out_final_row,
  output logic [COL_W-1:0]        out_texel_column,
  output logic [FIX_W-1:0]        out_texel_step,
  output logic [FIX_W-1:0]        out_texel_start
);

  rwc_cfg_t cfg_r, cfg_nxt;
  logic     q_push, q_full, q_pop, q_empty;
  rwc_job_t q_job_in, q_job_out;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      case (cfg_index)
        CFG_SCREEN_HEIGHT:  cfg_nxt.screen_height  = cfg_data[SCREEN_W-1:0];
        CFG_TEXTURE_WIDTH:  cfg_nxt.texture_width  = cfg_data[TEX_W-1:0];
        CFG_TEXTURE_HEIGHT: cfg_nxt.texture_height = cfg_data[TEX_W-1:0];
        CFG_VIEWER_X:       cfg_nxt.viewer_x       = cfg_data[POS_W-1:0];
        CFG_VIEWER_Y:       cfg_nxt.viewer_y       = cfg_data[POS_W-1:0];
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;

  rwc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_hit_side     (in_hit_side),
    .in_direction_x  (in_direction_x),
    .in_direction_y  (in_direction_y),
    .in_hit_distance (in_hit_distance),
    .in_wall_height  (in_wall_height),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_job_in)
  );

  rwc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (q_job_in),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (q_job_out),
    .empty   (q_empty)
  );

  rwc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_job            (q_job_out),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_texture_id   (out_texture_id),
    .out_first_row    (out_first_row),
    .out_final_row    (out_final_row),
    .out_texel_column (out_texel_column),
    .out_texel_step   (out_texel_step),
    .out_texel_start  (out_texel_start)
  );

endmodule

### sv/rwc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the wall column setup unit, attached by bind.
// Depends on rwc_pkg and raycast_wall_column_setup_unit.
module rwc_checker import rwc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_push,
  input logic                    in_full,
  input logic                    out_empty,
  input logic                    out_pop,
  input logic [ROW_W-1:0]        out_first_row,
  input logic [ROW_W-1:0]        out_final_row,
  input logic [COL_W-1:0]        out_texel_column,
  input logic [FIX_W-1:0]        out_texel_step,
  input logic [FIX_W-1:0]        out_texel_start
);

  // queue entries plus the job in the back end plus the output register
  localparam int MAX_PEND = QUEUE_DEPTH + 2;
  localparam int PEND_W   = $clog2(MAX_PEND + 2);

  logic              in_acc, out_acc;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  assign in_acc  = in_push && !in_full;
  assign out_acc = out_pop && !out_empty;

  // Transactions accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Nothing is waiting right after reset
  a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> out_empty)
    else $error("result shown right after reset");

  // The clamped slice never starts below its end
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_first_row <= out_final_row))
    else $error("first row beyond final row");

  // No result without an outstanding ray
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (pend_r != '0))
    else $error("result delivered with no ray outstanding");

  // Input side only stalls when the internal buffering is really taken
  a_full_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> (pend_r >= PEND_W'(QUEUE_DEPTH)) && (pend_r <= PEND_W'(MAX_PEND)))
    else $error("input stalled with free buffering");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_texel_step) &&
                                  $stable(out_texel_start) && $stable(out_texel_column)))
    else $error("stalled result changed");

endmodule

bind raycast_wall_column_setup_unit rwc_checker u_rwc_checker (.*);
